@@ rtl/nmea_sentence_checker_macros.svh @@
// ----------------------------------------------------------------------------
// NMEA sentence checker assertion macros
// Property shorthands used by the port checker file of the block.
// ----------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_CHECKER_MACROS_SVH
`define NMEA_SENTENCE_CHECKER_MACROS_SVH

// same-cycle implication, disabled during reset
`define NMEACHK_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nmea checker: same-cycle property failed");

// next-cycle implication, disabled during reset
`define NMEACHK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nmea checker: next-cycle property failed");

`endif

@@ rtl/nmeachk_pkg.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence checker package
// Shared constants, sentence kind codes and the classified character type.
// ----------------------------------------------------------------------------
package nmeachk_pkg;

  localparam int MAX_LINE    = 128;
  localparam int MAX_FIELDS  = 20;
  localparam int LP_W        = $clog2(MAX_LINE + 1);
  localparam int FIELD_W     = $clog2(MAX_FIELDS);
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);
  localparam int SATS_W      = 7;
  localparam int FIX_W       = 4;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAT_A = 8'h41;

  localparam logic [FIX_W-1:0]  FIX_MAX  = 4'd15;
  localparam logic [SATS_W-1:0] SATS_MAX = 7'd99;
  localparam logic [SATS_W-1:0] MIN_SATS_RESET = 7'd4;

  localparam logic [FIELD_W-1:0] FLD_STATUS = FIELD_W'(2);
  localparam logic [FIELD_W-1:0] FLD_FIX    = FIELD_W'(6);
  localparam logic [FIELD_W-1:0] FLD_SATS   = FIELD_W'(7);
  localparam logic [FIELD_W-1:0] FLD_LAST   = FIELD_W'(MAX_FIELDS - 1);
  // minimum field counts, expressed as the comma count (fields - 1)
  localparam logic [FIELD_W-1:0] MIN_CM_GGA = FIELD_W'(9);
  localparam logic [FIELD_W-1:0] MIN_CM_RMC = FIELD_W'(2);
  localparam logic [FIELD_W-1:0] MIN_CM_VTG = FIELD_W'(7);

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_GGA   = 2'd1,
    KIND_RMC   = 2'd2,
    KIND_VTG   = 2'd3
  } kind_t;

  typedef struct packed {
    logic       is_lf;
    logic       is_star;
    logic       is_comma;
    logic       is_dec;
    logic       hex_ok;
    logic [3:0] nib;
    logic [7:0] ch;
  } char_t;

endpackage

@@ rtl/nmeachk_front.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence checker front end
// Accepts bytes, drops carriage returns and classifies each character.
// ----------------------------------------------------------------------------
module nmeachk_front (
  input  logic                in_valid,
  input  logic [7:0]          in_data_byte,
  output logic                in_stall,
  input  logic                fifo_full,
  output logic                push,
  output nmeachk_pkg::char_t  push_item
);

  logic       is_num;
  logic       is_upper;
  logic       is_lower;
  logic [7:0] hex_diff;

  always_comb begin
    is_num   = (in_data_byte >= 8'h30) && (in_data_byte <= 8'h39);
    is_upper = (in_data_byte >= 8'h41) && (in_data_byte <= 8'h46);
    is_lower = (in_data_byte >= 8'h61) && (in_data_byte <= 8'h66);
    priority if (is_num) begin
      hex_diff = in_data_byte - 8'h30;
    end else if (is_upper) begin
      hex_diff = in_data_byte - 8'h37;
    end else begin
      hex_diff = in_data_byte - 8'h57;
    end

    push_item.is_lf    = (in_data_byte == nmeachk_pkg::CH_LF);
    push_item.is_star  = (in_data_byte == nmeachk_pkg::CH_STAR);
    push_item.is_comma = (in_data_byte == nmeachk_pkg::CH_COMMA);
    push_item.is_dec   = is_num;
    push_item.hex_ok   = is_num || is_upper || is_lower;
    push_item.nib      = hex_diff[3:0];
    push_item.ch       = in_data_byte;
  end

  assign in_stall = fifo_full;
  // drop carriage returns at the door
  assign push     = in_valid && !fifo_full && (in_data_byte != nmeachk_pkg::CH_CR);

endmodule

@@ rtl/nmeachk_fifo.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence checker character queue
// Short register queue between the front end and the line engine.
// ----------------------------------------------------------------------------
module nmeachk_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  nmeachk_pkg::char_t  push_item,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output nmeachk_pkg::char_t  head_item
);

  nmeachk_pkg::char_t                 mem_r [nmeachk_pkg::FIFO_DEPTH];
  logic [nmeachk_pkg::FIFO_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [nmeachk_pkg::FIFO_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [nmeachk_pkg::FIFO_CW-1:0]    count_r, count_nxt;
  logic                               do_pop;

  assign full       = (count_r == nmeachk_pkg::FIFO_CW'(nmeachk_pkg::FIFO_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    unique case ({push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ rtl/nmeachk_back.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence checker line engine
// Tracks checksum, prefix and fields per line and registers the verdict.
// ----------------------------------------------------------------------------
module nmeachk_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [nmeachk_pkg::SATS_W-1:0]        cfg_wr_data,
  input  logic                                  head_valid,
  input  nmeachk_pkg::char_t                    head_item,
  output logic                                  pop,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [1:0]                            out_sentence_kind,
  output logic                                  out_checksum_ok,
  output logic                                  out_fields_ok,
  output logic                                  out_sentence_valid,
  output logic [nmeachk_pkg::FIX_W-1:0]         out_fix_quality,
  output logic [nmeachk_pkg::SATS_W-1:0]        out_satellite_count,
  output logic                                  out_fix_3d,
  output logic                                  out_overlong
);

  localparam logic [nmeachk_pkg::LP_W-1:0] LP_LIMIT =
    nmeachk_pkg::LP_W'(nmeachk_pkg::MAX_LINE - 1);
  localparam logic [nmeachk_pkg::LP_W-1:0] LP_OVER =
    nmeachk_pkg::LP_W'(nmeachk_pkg::MAX_LINE);
  localparam logic [nmeachk_pkg::LP_W-1:0] LP_PREFIX = nmeachk_pkg::LP_W'(6);

  logic [nmeachk_pkg::SATS_W-1:0]  min_sats_r;

  logic [nmeachk_pkg::LP_W-1:0]    lp_r, lp_nxt;
  logic [7:0]                      prefix_r [6];
  logic [7:0]                      xor_r, xor_nxt;
  logic                            star_r, star_nxt;
  logic [1:0]                      hcnt_r, hcnt_nxt;
  logic [7:0]                      rcheck_r, rcheck_nxt;
  logic                            hbad_r, hbad_nxt;
  logic [nmeachk_pkg::FIELD_W-1:0] fidx_r, fidx_nxt;
  logic [nmeachk_pkg::FIX_W-1:0]   fix_r, fix_nxt;
  logic [nmeachk_pkg::SATS_W-1:0]  sats_r, sats_nxt;
  logic                            dstop_r, dstop_nxt;
  logic [7:0]                      status_r, status_nxt;

  logic                            out_valid_r;
  nmeachk_pkg::kind_t              kind_r;
  logic                            ck_r, fok_r, valid_r, f3d_r, over_r;
  logic [nmeachk_pkg::FIX_W-1:0]   fixq_r;
  logic [nmeachk_pkg::SATS_W-1:0]  satsq_r;

  logic                            take;
  logic                            emit;
  logic                            prefix_wr;
  logic [7:0]                      fix_acc;
  logic [9:0]                      sats_acc;
  logic                            gtalk;

  nmeachk_pkg::kind_t              v_kind;
  logic                            v_over, v_ck, v_fok, v_valid, v_f3d;
  logic [nmeachk_pkg::FIX_W-1:0]   v_fix;
  logic [nmeachk_pkg::SATS_W-1:0]  v_sats;

  assign pop  = head_valid && (!head_item.is_lf || !out_valid_r || !out_stall);
  assign take = pop && !head_item.is_lf && (lp_r < LP_LIMIT);
  assign emit = pop && head_item.is_lf && (lp_r != '0);
  assign prefix_wr = take && (lp_r < LP_PREFIX);

  // character engine
  always_comb begin
    lp_nxt     = lp_r;
    xor_nxt    = xor_r;
    star_nxt   = star_r;
    hcnt_nxt   = hcnt_r;
    rcheck_nxt = rcheck_r;
    hbad_nxt   = hbad_r;
    fidx_nxt   = fidx_r;
    fix_nxt    = fix_r;
    sats_nxt   = sats_r;
    dstop_nxt  = dstop_r;
    status_nxt = status_r;
    fix_acc    = {4'b0, fix_r} * 8'd10 + {4'b0, head_item.nib};
    sats_acc   = {3'b0, sats_r} * 10'd10 + {6'b0, head_item.nib};

    if (pop && head_item.is_lf) begin
      lp_nxt     = '0;
      xor_nxt    = '0;
      star_nxt   = 1'b0;
      hcnt_nxt   = '0;
      rcheck_nxt = '0;
      hbad_nxt   = 1'b0;
      fidx_nxt   = '0;
      fix_nxt    = '0;
      sats_nxt   = '0;
      dstop_nxt  = 1'b0;
      status_nxt = '0;
    end else if (pop && !take) begin
      // overlong: drop the character, mark the line
      lp_nxt = LP_OVER;
    end else if (take) begin
      if (star_r) begin
        if (hcnt_r != 2'd2) begin
          if (!head_item.hex_ok) begin
            hbad_nxt = 1'b1;
          end else begin
            rcheck_nxt = {rcheck_r[3:0], head_item.nib};
          end
          hcnt_nxt = hcnt_r + 2'd1;
        end
      end else if (head_item.is_star) begin
        star_nxt = 1'b1;
      end else if (lp_r != '0) begin
        xor_nxt = xor_r ^ head_item.ch;
      end

      if (head_item.is_comma) begin
        if (fidx_r < nmeachk_pkg::FLD_LAST) begin
          fidx_nxt = fidx_r + 1'b1;
        end
        dstop_nxt = 1'b0;
      end else if (!dstop_r) begin
        if (fidx_r == nmeachk_pkg::FLD_STATUS) begin
          status_nxt = head_item.ch;
          dstop_nxt  = 1'b1;
        end else if (fidx_r == nmeachk_pkg::FLD_FIX || fidx_r == nmeachk_pkg::FLD_SATS) begin
          if (head_item.is_dec) begin
            if (fidx_r == nmeachk_pkg::FLD_FIX) begin
              fix_nxt = (fix_acc > {4'b0, nmeachk_pkg::FIX_MAX}) ?
                        nmeachk_pkg::FIX_MAX : fix_acc[nmeachk_pkg::FIX_W-1:0];
            end else begin
              sats_nxt = (sats_acc > {3'b0, nmeachk_pkg::SATS_MAX}) ?
                         nmeachk_pkg::SATS_MAX : sats_acc[nmeachk_pkg::SATS_W-1:0];
            end
          end else begin
            dstop_nxt = 1'b1;
          end
        end else begin
          dstop_nxt = 1'b1;
        end
      end
      lp_nxt = lp_r + 1'b1;
    end
  end

  // verdict
  always_comb begin
    gtalk = (prefix_r[0] == nmeachk_pkg::CH_DOLLAR) && (prefix_r[1] == 8'h47) &&
            (prefix_r[2] == 8'h50 || prefix_r[2] == 8'h4E);
    v_kind = nmeachk_pkg::KIND_OTHER;
    if (lp_r >= LP_PREFIX && gtalk) begin
      priority if (prefix_r[3] == 8'h47 && prefix_r[4] == 8'h47 && prefix_r[5] == 8'h41) begin
        v_kind = nmeachk_pkg::KIND_GGA;
      end else if (prefix_r[3] == 8'h52 && prefix_r[4] == 8'h4D &&
                   prefix_r[5] == 8'h43) begin
        v_kind = nmeachk_pkg::KIND_RMC;
      end else if (prefix_r[3] == 8'h56 && prefix_r[4] == 8'h54 &&
                   prefix_r[5] == 8'h47) begin
        v_kind = nmeachk_pkg::KIND_VTG;
      end else begin
        v_kind = nmeachk_pkg::KIND_OTHER;
      end
    end
    v_over = (lp_r >= LP_OVER);
    v_ck   = star_r && (hcnt_r == 2'd2) && !hbad_r && (xor_r == rcheck_r) && !v_over;
    unique case (v_kind)
      nmeachk_pkg::KIND_GGA: v_fok = !v_over && (fidx_r >= nmeachk_pkg::MIN_CM_GGA);
      nmeachk_pkg::KIND_RMC: v_fok = !v_over && (fidx_r >= nmeachk_pkg::MIN_CM_RMC);
      nmeachk_pkg::KIND_VTG: v_fok = !v_over && (fidx_r >= nmeachk_pkg::MIN_CM_VTG);
      default:               v_fok = 1'b0;
    endcase
    v_valid = 1'b0;
    v_fix   = '0;
    v_sats  = '0;
    v_f3d   = 1'b0;
    if (v_ck && v_fok) begin
      unique case (v_kind)
        nmeachk_pkg::KIND_GGA: begin
          v_fix   = fix_r;
          v_sats  = sats_r;
          v_valid = (fix_r != '0);
          v_f3d   = (fix_r != '0) && (sats_r >= min_sats_r);
        end
        nmeachk_pkg::KIND_RMC: v_valid = (status_r == nmeachk_pkg::CH_STAT_A);
        nmeachk_pkg::KIND_VTG: v_valid = 1'b1;
        default:               v_valid = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_sats_r  <= nmeachk_pkg::MIN_SATS_RESET;
      lp_r        <= '0;
      xor_r       <= '0;
      star_r      <= 1'b0;
      hcnt_r      <= '0;
      rcheck_r    <= '0;
      hbad_r      <= 1'b0;
      fidx_r      <= '0;
      fix_r       <= '0;
      sats_r      <= '0;
      dstop_r     <= 1'b0;
      status_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        min_sats_r <= cfg_wr_data;
      end
      lp_r     <= lp_nxt;
      xor_r    <= xor_nxt;
      star_r   <= star_nxt;
      hcnt_r   <= hcnt_nxt;
      rcheck_r <= rcheck_nxt;
      hbad_r   <= hbad_nxt;
      fidx_r   <= fidx_nxt;
      fix_r    <= fix_nxt;
      sats_r   <= sats_nxt;
      dstop_r  <= dstop_nxt;
      status_r <= status_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prefix_wr) begin
      prefix_r[lp_r[2:0]] <= head_item.ch;
    end
    if (emit) begin
      kind_r  <= v_kind;
      ck_r    <= v_ck;
      fok_r   <= v_fok;
      valid_r <= v_valid;
      fixq_r  <= v_fix;
      satsq_r <= v_sats;
      f3d_r   <= v_f3d;
      over_r  <= v_over;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_sentence_kind   = kind_r;
  assign out_checksum_ok     = ck_r;
  assign out_fields_ok       = fok_r;
  assign out_sentence_valid  = valid_r;
  assign out_fix_quality     = fixq_r;
  assign out_satellite_count = satsq_r;
  assign out_fix_3d          = f3d_r;
  assign out_overlong        = over_r;

endmodule

@@ rtl/nmea_sentence_checker.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence checker
// Judges NMEA 0183 lines from a byte stream and emits one verdict per line.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall / in_data_byte, one character per
// transfer. Carriage returns are dropped; a line feed closes the line and,
// if the line held any character, yields one verdict on the out_ channel
// (out_valid / out_stall plus the verdict fields).
// Throughput: one character per cycle while in_stall is low, through the
// four-entry character queue in front of the line engine.
// A line feed is written into the queue; from the queue head it loads the
// verdict register, which raises out_valid for the verdict transfer.
// When the receiver stalls, the verdict holds; characters keep flowing into
// the line engine, and a following line feed waits in the queue. in_stall
// rises only when the queue is full.
// cfg_wr_en / cfg_wr_data set min_sats_for_3d; write it only while idle.
// Reset (rst_n low, synchronous) empties the queue, clears the line and
// out_valid (not the verdict fields) and sets min_sats_for_3d to 4.
// ----------------------------------------------------------------------------
module nmea_sentence_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [nmeachk_pkg::SATS_W-1:0]  cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_data_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_sentence_kind,
  output logic                            out_checksum_ok,
  output logic                            out_fields_ok,
  output logic                            out_sentence_valid,
  output logic [nmeachk_pkg::FIX_W-1:0]   out_fix_quality,
  output logic [nmeachk_pkg::SATS_W-1:0]  out_satellite_count,
  output logic                            out_fix_3d,
  output logic                            out_overlong
);

  logic               push;
  nmeachk_pkg::char_t push_item;
  logic               fifo_full;
  logic               pop;
  logic               head_valid;
  nmeachk_pkg::char_t head_item;

  nmeachk_front u_front (
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_stall     (in_stall),
    .fifo_full    (fifo_full),
    .push         (push),
    .push_item    (push_item)
  );

  nmeachk_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (fifo_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  nmeachk_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .head_valid          (head_valid),
    .head_item           (head_item),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_sentence_kind   (out_sentence_kind),
    .out_checksum_ok     (out_checksum_ok),
    .out_fields_ok       (out_fields_ok),
    .out_sentence_valid  (out_sentence_valid),
    .out_fix_quality     (out_fix_quality),
    .out_satellite_count (out_satellite_count),
    .out_fix_3d          (out_fix_3d),
    .out_overlong        (out_overlong)
  );

endmodule

@@ rtl/nmeachk_checker.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence checker port checker
// Verdict consistency and output hold checks, bound to the top level.
// ----------------------------------------------------------------------------
`include "nmea_sentence_checker_macros.svh"

module nmeachk_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [1:0]                      out_sentence_kind,
  input  logic                            out_checksum_ok,
  input  logic                            out_fields_ok,
  input  logic                            out_sentence_valid,
  input  logic [nmeachk_pkg::FIX_W-1:0]   out_fix_quality,
  input  logic [nmeachk_pkg::SATS_W-1:0]  out_satellite_count,
  input  logic                            out_fix_3d,
  input  logic                            out_overlong
);

  `NMEACHK_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_sentence_kind) && $stable(out_sentence_valid) &&
    $stable(out_satellite_count))

  `NMEACHK_ASSERT_NOW(a_overlong_zero, out_valid && out_overlong,
    !out_checksum_ok && !out_fields_ok && !out_sentence_valid &&
    out_fix_quality == '0 && out_satellite_count == '0)

  `NMEACHK_ASSERT_NOW(a_valid_needs_checks, out_valid && out_sentence_valid,
    out_checksum_ok && out_fields_ok && out_sentence_kind != nmeachk_pkg::KIND_OTHER)

  `NMEACHK_ASSERT_NOW(a_fix3d_gga, out_valid && out_fix_3d,
    out_sentence_valid && out_sentence_kind == nmeachk_pkg::KIND_GGA &&
    out_fix_quality != '0)

  `NMEACHK_ASSERT_NOW(a_non_gga_zero, out_valid && out_sentence_kind != nmeachk_pkg::KIND_GGA,
    out_fix_quality == '0 && out_satellite_count == '0 && !out_fix_3d)

endmodule

bind nmea_sentence_checker nmeachk_checker u_nmeachk_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_sentence_kind   (out_sentence_kind),
  .out_checksum_ok     (out_checksum_ok),
  .out_fields_ok       (out_fields_ok),
  .out_sentence_valid  (out_sentence_valid),
  .out_fix_quality     (out_fix_quality),
  .out_satellite_count (out_satellite_count),
  .out_fix_3d          (out_fix_3d),
  .out_overlong        (out_overlong)
);
